@@ hdl/vpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpi_pkg
// Shared types and constants for the velocity-form PI controller: item
// structs, operation and register codes, fixed-point widths.
// ----------------------------------------------------------------------------
package vpi_pkg;

  // fixed-point layout of the drive output (unsigned 16.16)
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 16;
  localparam int OUT_W     = 32;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // accumulator + p + i - previous p needs two extra magnitude bits and a sign
  localparam int SUM_W     = OUT_W + 3;
  localparam int PROD_W    = OUT_W + 1;

  // configuration register port
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PGAIN = 1'b0,
    CFG_IGAIN = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_STEP   = 1'b0,
    OP_PRESET = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [DATA_W-1:0] error_value;
    logic [DATA_W-1:0]        preset_output;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] drive_output;
    logic             saturated;
  } out_item_t;

  // controller state carried from one item to the next
  typedef struct packed {
    logic [OUT_W-1:0]        acc;
    logic signed [OUT_W-1:0] prev_p;
  } vpi_state_t;

endpackage

@@ hdl/vpi_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpi_step
// Combinational update for one item: two gain products, the wide velocity
// sum, clamp to the unsigned 16.16 range, and the preset path.
// ----------------------------------------------------------------------------
module vpi_step (
  input  vpi_pkg::in_item_t           item,
  input  logic [vpi_pkg::DATA_W-1:0]  pgain,
  input  logic [vpi_pkg::DATA_W-1:0]  igain,
  input  vpi_pkg::vpi_state_t         state_cur,
  output vpi_pkg::vpi_state_t         state_next,
  output vpi_pkg::out_item_t          result
);

  logic signed [vpi_pkg::PROD_W-1:0] p_full;
  logic signed [vpi_pkg::PROD_W-1:0] i_full;
  logic signed [vpi_pkg::SUM_W-1:0]  sum;
  logic                              under;
  logic                              over;

  // signed error times unsigned gain, exact
  assign p_full = $signed(item.error_value) * $signed({1'b0, pgain});
  assign i_full = $signed(item.error_value) * $signed({1'b0, igain});

  // old output + p + i - previous p, with room for both overflow directions
  assign sum = $signed({3'b000, state_cur.acc})
             + $signed({{2{p_full[vpi_pkg::PROD_W-1]}}, p_full})
             + $signed({{2{i_full[vpi_pkg::PROD_W-1]}}, i_full})
             - $signed({{3{state_cur.prev_p[vpi_pkg::OUT_W-1]}}, state_cur.prev_p});

  assign under = sum[vpi_pkg::SUM_W-1];
  assign over  = !sum[vpi_pkg::SUM_W-1] && (sum[vpi_pkg::SUM_W-2:vpi_pkg::OUT_W] != '0);

  // select preset, clamp or plain update
  always_comb begin
    state_next = state_cur;
    result     = '0;
    if (item.operation == vpi_pkg::OP_PRESET) begin
      state_next.acc    = vpi_pkg::OUT_W'(item.preset_output) << vpi_pkg::FRAC_BITS;
      state_next.prev_p = '0;
      result.saturated  = 1'b0;
    end else if (under) begin
      state_next.acc    = '0;
      state_next.prev_p = '0;
      result.saturated  = 1'b1;
    end else if (over) begin
      state_next.acc    = vpi_pkg::OUT_MAX;
      state_next.prev_p = '0;
      result.saturated  = 1'b1;
    end else begin
      state_next.acc    = sum[vpi_pkg::OUT_W-1:0];
      state_next.prev_p = p_full[vpi_pkg::OUT_W-1:0];
      result.saturated  = 1'b0;
    end
    result.drive_output = state_next.acc;
  end

endmodule

@@ hdl/velocity_pi_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_pi_controller_top
// Incremental PI controller with a 16.16 unsigned output. Each item is a
// control step on a signed error or a preset of the output; each item gives
// one result with the new output and a clamp flag.
// ----------------------------------------------------------------------------
// The block takes one item every clock cycle while the output side is ready.
// Each item is captured in an input register, the whole update (two 16x16
// gain products, one 35-bit sum and the clamp) runs against the accumulator
// while the item sits in that register, and the
// result lands in an output register. The accumulator and stored proportional
// term are updated as the item leaves the input register, so back-to-back
// items see each other's state. While a result waits in the output register
// one more item is still accepted into the input register. Gains are written
// through the configuration port, which is always ready; write them only
// while no item is in flight.
module velocity_pi_controller_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vpi_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vpi_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpi_pkg::DATA_W-1:0]       cfg_data
);

  logic [vpi_pkg::DATA_W-1:0] pgain;
  logic [vpi_pkg::DATA_W-1:0] igain;
  logic                       s1_valid;
  vpi_pkg::in_item_t          s1_item;
  logic                       s1_move;
  vpi_pkg::vpi_state_t        state;
  vpi_pkg::vpi_state_t        state_next;
  vpi_pkg::out_item_t         result;

  assign cfg_ready = 1'b1;

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pgain <= '0;
      igain <= '0;
    end else if (cfg_valid) begin
      unique case (vpi_pkg::cfg_reg_t'(cfg_index))
        vpi_pkg::CFG_PGAIN: pgain <= cfg_data;
        vpi_pkg::CFG_IGAIN: igain <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: stage one advances when the output register is free or drains
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // per-item update
  vpi_step u_step (
    .item       (s1_item),
    .pgain      (pgain),
    .igain      (igain),
    .state_cur  (state),
    .state_next (state_next),
    .result     (result)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item <= result;
    end
  end

endmodule

@@ hdl/vpi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpi_checker
// Port-level checks for the PI controller, bound to the top level.
// ----------------------------------------------------------------------------
module vpi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input vpi_pkg::out_item_t            out_item,
  input logic                          cfg_ready
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a clamped result sits at one of the two range limits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.saturated |->
      out_item.drive_output == '0 || out_item.drive_output == vpi_pkg::OUT_MAX)
    else $error("saturated result away from the range limits");

  // input back-pressure only with a result waiting
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid && cfg_ready)
    else $error("result valid straight after reset");

endmodule

bind velocity_pi_controller_top vpi_checker u_vpi_checker (.*);
